>>> rtl/gpio_pin_table_edge_interrupt_core_defines.svh
// ============================================================================
// GPIO pin table assertion macros
// Shorthand for the concurrent checks at the end of the pin table core.
// ============================================================================
`ifndef GPIO_PIN_TABLE_EDGE_INTERRUPT_CORE_DEFINES_SVH
`define GPIO_PIN_TABLE_EDGE_INTERRUPT_CORE_DEFINES_SVH

// Same-cycle implication on clk, disabled while rst_n is low.
`define GPTE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pin table check failed");

// Next-cycle implication on clk, disabled while rst_n is low.
`define GPTE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pin table check failed");

`endif

>>> rtl/gpte_pkg.sv
// ============================================================================
// GPIO pin table package
// Request and interrupt mode codes and the fixed field widths of the core.
// ============================================================================
`timescale 1ns / 1ps

package gpte_pkg;

    // Fixed widths of the item fields.
    localparam int REQ_W       = 3;
    localparam int PIN_W       = 8;
    localparam int VALUE_W     = 16;
    localparam int MODE_W      = 2;
    localparam int LEVEL_OUT_W = 10;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_ANALOG  = 3'd0,
        REQ_DIGITAL = 3'd1,
        REQ_READ    = 3'd2,
        REQ_ATTACH  = 3'd3,
        REQ_DETACH  = 3'd4,
        REQ_ENABLE  = 3'd5
    } req_t;

    // Interrupt mode codes.
    typedef enum logic [MODE_W-1:0] {
        MODE_NONE    = 2'd0,
        MODE_CHANGE  = 2'd1,
        MODE_RISING  = 2'd2,
        MODE_FALLING = 2'd3
    } mode_t;

    // Widest level the core can hold, used to report a level in its field.
    typedef logic [VALUE_W-1:0] wide_level_t;

endpackage

>>> rtl/gpio_pin_table_edge_interrupt_core.sv
// ============================================================================
// GPIO pin table with edge interrupts
// One entry per pin holding a level and an interrupt mode. Writes, reads,
// attach and detach requests address one entry; a write whose digital edge
// matches the pin's mode raises an interrupt naming the pin.
//
//   Channel | Handshake                  | Payload
//   --------+----------------------------+------------------------------------
//   input   | in_valid / in_stall        | req_type pin write_value irq_mode
//           |                            | enable
//   output  | out_valid / out_stall      | level digital irq_fire irq_pin
//
// The entry is read into the read register at the accepting edge, modified in
// the modify stage and written back as the item moves to the output register.
// With the output free one item is accepted per cycle; the last write is
// forwarded so that consecutive items on one pin agree.
// Reset clears per-entry valid bits, so the table reads as zero at once.
// A held result stalls the input once the modify stage is also occupied.
// ============================================================================
`timescale 1ns / 1ps

`include "gpio_pin_table_edge_interrupt_core_defines.svh"

module gpio_pin_table_edge_interrupt_core #(
    parameter int PIN_COUNT  = 256,
    parameter int LEVEL_BITS = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [gpte_pkg::REQ_W-1:0]        req_type,
    input  logic [gpte_pkg::PIN_W-1:0]        pin,
    input  logic [gpte_pkg::VALUE_W-1:0]      write_value,
    input  logic [gpte_pkg::MODE_W-1:0]       irq_mode,
    input  logic                              enable,
    // Result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [gpte_pkg::LEVEL_OUT_W-1:0]  level,
    output logic                              digital,
    output logic                              irq_fire,
    output logic [gpte_pkg::PIN_W-1:0]        irq_pin
);

    localparam int PIN_IDX_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
    localparam logic [gpte_pkg::PIN_W:0] PIN_LIMIT = (gpte_pkg::PIN_W + 1)'(PIN_COUNT);

    typedef struct packed {
        logic [gpte_pkg::MODE_W-1:0] mode;
        logic [LEVEL_BITS-1:0]       lvl;
    } entry_t;

    // Pin memory and its registered read port.
    entry_t                         pin_mem [PIN_COUNT];
    entry_t                         mem_q_reg;
    logic [PIN_COUNT-1:0]           entry_valid_reg;

    // Modify stage.
    logic                           s1_valid_reg;
    logic [gpte_pkg::REQ_W-1:0]     s1_req_reg;
    logic [gpte_pkg::PIN_W-1:0]     s1_pin_reg;
    logic [gpte_pkg::VALUE_W-1:0]   s1_value_reg;
    logic [gpte_pkg::MODE_W-1:0]    s1_mode_reg;
    logic                           s1_enable_reg;

    // Last written entry, forwarded to the item that follows.
    logic                           fwd_valid_reg;
    logic [gpte_pkg::PIN_W-1:0]     fwd_pin_reg;
    entry_t                         fwd_entry_reg;

    logic                           global_irq_enable_reg;
    logic                           global_irq_enable_next;

    // Output register.
    logic                              out_valid_reg;
    logic [gpte_pkg::LEVEL_OUT_W-1:0]  level_reg;
    logic [gpte_pkg::LEVEL_OUT_W-1:0]  level_next;
    logic                              digital_reg;
    logic                              digital_next;
    logic                              irq_fire_reg;
    logic                              irq_fire_next;
    logic [gpte_pkg::PIN_W-1:0]        irq_pin_reg;
    logic [gpte_pkg::PIN_W-1:0]        irq_pin_next;

    logic                           in_accept;
    logic                           s1_advance;
    logic [PIN_IDX_W-1:0]           in_idx;
    logic [PIN_IDX_W-1:0]           s1_idx;
    logic                           s1_in_range;
    entry_t                         old_entry;
    entry_t                         new_entry;
    logic                           mem_we;
    logic                           store_lvl;
    logic                           was_high;
    logic                           is_high;
    logic                           rise;
    logic                           fall;
    logic                           edge_match;
    gpte_pkg::wide_level_t          lvl_wide;

    // Handshake: the modify stage moves on when the output register is free.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    assign in_idx      = pin[PIN_IDX_W-1:0];
    assign s1_idx      = s1_pin_reg[PIN_IDX_W-1:0];
    assign s1_in_range = {1'b0, s1_pin_reg} < PIN_LIMIT;

    // Current entry: forwarded write, else memory, else the reset value.
    always_comb
    begin
        priority if (fwd_valid_reg && (fwd_pin_reg == s1_pin_reg))
        begin
            old_entry = fwd_entry_reg;
        end
        else if (entry_valid_reg[s1_idx])
        begin
            old_entry = mem_q_reg;
        end
        else
        begin
            old_entry = '0;
        end
    end

    // Modify the entry according to the request.
    always_comb
    begin
        new_entry = old_entry;
        store_lvl = 1'b0;
        mem_we    = 1'b0;
        unique case (s1_req_reg)
            gpte_pkg::REQ_ANALOG:
            begin
                new_entry.lvl = s1_value_reg[LEVEL_BITS-1:0];
                store_lvl     = 1'b1;
                mem_we        = s1_in_range;
            end
            gpte_pkg::REQ_DIGITAL:
            begin
                new_entry.lvl = (s1_value_reg == '0) ? '0 : {LEVEL_BITS{1'b1}};
                store_lvl     = 1'b1;
                mem_we        = s1_in_range;
            end
            gpte_pkg::REQ_ATTACH:
            begin
                new_entry.mode = s1_mode_reg;
                mem_we         = s1_in_range;
            end
            gpte_pkg::REQ_DETACH:
            begin
                new_entry.mode = gpte_pkg::MODE_NONE;
                mem_we         = s1_in_range;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Edge detection against the pin's interrupt mode.
    assign was_high = old_entry.lvl != '0;
    assign is_high  = new_entry.lvl != '0;
    assign rise     = !was_high && is_high;
    assign fall     = was_high && !is_high;

    always_comb
    begin
        unique case (old_entry.mode)
            gpte_pkg::MODE_CHANGE:  edge_match = rise || fall;
            gpte_pkg::MODE_RISING:  edge_match = rise;
            gpte_pkg::MODE_FALLING: edge_match = fall;
            default:                edge_match = 1'b0;
        endcase
    end

    // Result of the item in the modify stage.
    assign lvl_wide = gpte_pkg::wide_level_t'(new_entry.lvl);

    always_comb
    begin
        if (s1_in_range)
        begin
            level_next    = lvl_wide[gpte_pkg::LEVEL_OUT_W-1:0];
            digital_next  = is_high;
            irq_fire_next = store_lvl && global_irq_enable_reg && edge_match;
        end
        else
        begin
            level_next    = '0;
            digital_next  = 1'b0;
            irq_fire_next = 1'b0;
        end
        irq_pin_next = irq_fire_next ? s1_pin_reg : '0;
    end

    // The global enable follows its own request whatever the pin.
    assign global_irq_enable_next =
        (s1_advance && (s1_req_reg == gpte_pkg::REQ_ENABLE)) ? s1_enable_reg
                                                             : global_irq_enable_reg;

    // Pin memory: write back from the modify stage, read for a new item.
    always_ff @(posedge clk)
    begin
        if (s1_advance && mem_we)
        begin
            pin_mem[s1_idx] <= new_entry;
        end
        if (in_accept)
        begin
            mem_q_reg <= pin_mem[in_idx];
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            fwd_valid_reg         <= 1'b0;
            entry_valid_reg       <= '0;
            global_irq_enable_reg <= 1'b1;
        end
        else
        begin
            priority if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            priority if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (s1_advance && mem_we)
            begin
                fwd_valid_reg           <= 1'b1;
                entry_valid_reg[s1_idx] <= 1'b1;
            end
            global_irq_enable_reg <= global_irq_enable_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_req_reg    <= req_type;
            s1_pin_reg    <= pin;
            s1_value_reg  <= write_value;
            s1_mode_reg   <= irq_mode;
            s1_enable_reg <= enable;
        end
        if (s1_advance && mem_we)
        begin
            fwd_pin_reg   <= s1_pin_reg;
            fwd_entry_reg <= new_entry;
        end
        if (s1_advance)
        begin
            level_reg    <= level_next;
            digital_reg  <= digital_next;
            irq_fire_reg <= irq_fire_next;
            irq_pin_reg  <= irq_pin_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign level     = level_reg;
    assign digital   = digital_reg;
    assign irq_fire  = irq_fire_reg;
    assign irq_pin   = irq_pin_reg;

    // Checks.
    `GPTE_ASSERT_IMP(a_fire_needs_enable, out_valid_reg && irq_fire_reg, global_irq_enable_reg)
    `GPTE_ASSERT_IMP(a_quiet_pin_zero, out_valid_reg && !irq_fire_reg, irq_pin_reg == '0)
    `GPTE_ASSERT_IMP(a_stall_only_when_busy, in_stall, s1_valid_reg && out_valid_reg)
    `GPTE_ASSERT_NXT(a_held_item_stays, in_stall, s1_valid_reg && $stable(s1_pin_reg))

endmodule
